FILE: hdl/rmf_pkg.sv
`default_nettype none

package rmf_pkg;

  // Line length the line stores are sized for
  localparam int MAX_WIDTH = 2048;
  localparam int TAPS      = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Frame geometry
  localparam int ROW_W     = 12;
  localparam int ROW_LIMIT = 4095;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WMAX      = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
  localparam int WCMP_W    = ((COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W) + 1;
  localparam int AREA_W    = $clog2(WMAX * ROW_LIMIT + 1);

  // Register reset values and the matching frame area
  localparam int WIDTH_RESET      = 640;
  localparam int HEIGHT_RESET     = 480;
  localparam int WIDTH_RESET_EFF  = (WIDTH_RESET < WMAX) ? WIDTH_RESET : WMAX;
  localparam int AREA_RESET       = WIDTH_RESET_EFF * HEIGHT_RESET;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // One line store entry: the pixel two lines up and the pixel one line up
  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_t;

  typedef struct packed {
    pixel_t pix;
    logic   frame_end;
  } result_t;

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rmf_ram.sv
`default_nettype none

module rmf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rmf_median.sv
`default_nettype none

// Median of nine, one channel, three register stages.
// Taps are column-major: tap col*3 + row.
module rmf_median import rmf_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [TAPS*TAPS-1:0][7:0]  taps,
  output chan_t                      med
);

  chan_t col_lo  [TAPS];
  chan_t col_mid [TAPS];
  chan_t col_hi  [TAPS];
  chan_t max_lo;
  chan_t med_mid;
  chan_t min_hi;

  // Sort each column
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < TAPS; j++) begin
        col_lo[j]  <= min3(taps[j*TAPS], taps[j*TAPS+1], taps[j*TAPS+2]);
        col_mid[j] <= med3(taps[j*TAPS], taps[j*TAPS+1], taps[j*TAPS+2]);
        col_hi[j]  <= max3(taps[j*TAPS], taps[j*TAPS+1], taps[j*TAPS+2]);
      end
    end
  end

  // Across columns: largest low, middle mid, smallest high
  always_ff @(posedge clk) begin
    if (en) begin
      max_lo  <= max3(col_lo[0], col_lo[1], col_lo[2]);
      med_mid <= med3(col_mid[0], col_mid[1], col_mid[2]);
      min_hi  <= min3(col_hi[0], col_hi[1], col_hi[2]);
    end
  end

  // Median of the three candidates
  always_ff @(posedge clk) begin
    if (en) begin
      med <= med3(max_lo, med_mid, min_hi);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rmf_out_buf.sv
`default_nettype none

// Two-entry output queue; lets the pipeline keep moving while a result waits.
module rmf_out_buf import rmf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rgb_median_filter_3x3.sv
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    red_in, green_in, blue_in, padding
// output    out_valid / out_ready  red_out, green_out, blue_out, frame_end
// config    cfg_write              cfg_index, cfg_data (image_width, image_height)
//
// One pixel per clock while the output queue has room. A result passes through
// the line store read, the window register, the three-stage median network
// and the output queue register after the transfer that causes it.
// The line store is one 48-bit RAM; a read of the entry that is being written
// in the same cycle (one-pixel lines) is served from a forwarding register.
// Reset (rst, synchronous) clears counters, valids and the window; the line
// store is not cleared. A full output queue holds the whole pipeline.
module rgb_median_filter_3x3 import rmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  input  logic                  padding,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out,
  output logic                  frame_end,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic   vld;
    logic   interior;
    logic   last;
    pixel_t pass;
  } tag_t;

  function automatic logic [CFG_DATA_W-1:0] width_eff(logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return CFG_DATA_W'(1);
    end else if (v > CFG_DATA_W'(WMAX)) begin
      return CFG_DATA_W'(WMAX);
    end
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] height_eff(logic [CFG_DATA_W-1:0] v);
    return (v == '0) ? CFG_DATA_W'(1) : v;
  endfunction

  // Configuration registers and frame area
  logic [CFG_DATA_W-1:0]   image_width;
  logic [CFG_DATA_W-1:0]   image_height;
  logic [AREA_W-1:0]       area;
  logic [CFG_DATA_W-1:0]   w_eff;
  logic [CFG_DATA_W-1:0]   h_eff;
  logic [CFG_DATA_W-1:0]   mul_a;
  logic [CFG_DATA_W-1:0]   mul_b;
  logic [2*CFG_DATA_W-1:0] area_prod;

  assign w_eff = width_eff(image_width);
  assign h_eff = height_eff(image_height);

  always_comb begin
    if (cfg_index == REG_IMAGE_WIDTH) begin
      mul_a = width_eff(cfg_data);
      mul_b = h_eff;
    end else begin
      mul_a = w_eff;
      mul_b = height_eff(cfg_data);
    end
    area_prod = {{CFG_DATA_W{1'b0}}, mul_a} * {{CFG_DATA_W{1'b0}}, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_DATA_W'(WIDTH_RESET);
      image_height <= CFG_DATA_W'(HEIGHT_RESET);
      area         <= AREA_W'(AREA_RESET);
    end else if (cfg_write) begin
      area <= area_prod[AREA_W-1:0];
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline enable and input transfer
  logic   en;
  logic   accept;
  logic   buf_full;
  pixel_t pix_in;

  assign en       = !buf_full;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign pix_in   = padding ? '0 : pixel_t'({red_in, green_in, blue_in});

  // Raster position and output count
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [AREA_W-1:0] ocnt;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [AREA_W-1:0] ocnt_next;
  logic              emit;
  logic              interior;
  logic              last;
  logic              wrap;

  always_comb begin
    wrap     = (WCMP_W'(col) + WCMP_W'(1)) >= WCMP_W'(w_eff);
    emit     = (col == '0) ? (row >= ROW_W'(2)) : (row >= ROW_W'(1));
    interior = (row >= ROW_W'(2)) && (row < h_eff) && (col >= COL_W'(2)) &&
               (WCMP_W'(col) < WCMP_W'(w_eff));
    last     = emit && (({1'b0, ocnt} + 1'b1) >= {1'b0, area});
    col_next = wrap ? '0 : col + 1'b1;
    row_next = (wrap && row != ROW_W'(ROW_LIMIT)) ? row + 1'b1 : row;
    ocnt_next = ocnt;
    if (emit) begin
      ocnt_next = ocnt + 1'b1;
    end
    // End of frame restarts the raster
    if (last) begin
      ocnt_next = '0;
      col_next  = '0;
      row_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      ocnt <= '0;
    end else if (accept) begin
      col  <= col_next;
      row  <= row_next;
      ocnt <= ocnt_next;
    end
  end

  // Line store read stage
  logic             s1_vld;
  logic [COL_W-1:0] s1_addr;
  pixel_t           s1_pix;
  logic             s1_emit;
  logic             s1_interior;
  logic             s1_last;
  logic             fwd_hit;
  line_t            fwd_data;
  line_t            ram_rd;
  line_t            line_rd;
  line_t            line_wr;
  logic             ram_we;

  assign line_rd = fwd_hit ? fwd_data : ram_rd;
  assign line_wr = '{upper: line_rd.lower, lower: s1_pix};
  assign ram_we  = s1_vld && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr     <= col;
      s1_pix      <= pix_in;
      s1_emit     <= emit;
      s1_interior <= interior;
      s1_last     <= last;
      // Entry written this cycle is the one being read: forward it
      fwd_hit     <= s1_vld && (s1_addr == col);
      fwd_data    <= line_wr;
    end
  end

  rmf_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_addr),
    .wr_data (line_wr),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram_rd)
  );

  // 3x3 window, column 2 newest
  pixel_t win [TAPS][TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (en && s1_vld) begin
      for (int i = 0; i < TAPS; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= line_rd.upper;
      win[1][2] <= line_rd.lower;
      win[2][2] <= s1_pix;
    end
  end

  // Result tags, aligned with the median stages
  tag_t t2;
  tag_t t3;
  tag_t t4;
  tag_t t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.vld <= 1'b0;
      t3.vld <= 1'b0;
      t4.vld <= 1'b0;
      t5.vld <= 1'b0;
    end else if (en) begin
      t2.vld      <= s1_vld && s1_emit;
      // Border pixels take the center of the window after the shift
      t2.interior <= s1_interior;
      t2.last     <= s1_last;
      t2.pass     <= win[1][2];
      t3          <= t2;
      t4          <= t3;
      t5          <= t4;
    end
  end

  // Per-channel median lanes
  logic [TAPS*TAPS-1:0][7:0] taps_r;
  logic [TAPS*TAPS-1:0][7:0] taps_g;
  logic [TAPS*TAPS-1:0][7:0] taps_b;
  pixel_t                    med;

  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      for (int i = 0; i < TAPS; i++) begin
        taps_r[j*TAPS+i] = win[i][j].red;
        taps_g[j*TAPS+i] = win[i][j].green;
        taps_b[j*TAPS+i] = win[i][j].blue;
      end
    end
  end

  rmf_median u_med_red (
    .clk  (clk),
    .en   (en),
    .taps (taps_r),
    .med  (med.red)
  );

  rmf_median u_med_green (
    .clk  (clk),
    .en   (en),
    .taps (taps_g),
    .med  (med.green)
  );

  rmf_median u_med_blue (
    .clk  (clk),
    .en   (en),
    .taps (taps_b),
    .med  (med.blue)
  );

  // Output queue
  logic    push;
  result_t push_data;
  result_t buf_data;

  assign push      = en && t5.vld;
  assign push_data = '{pix: (t5.interior ? med : t5.pass), frame_end: t5.last};

  rmf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_data)
  );

  assign red_out   = buf_data.pix.red;
  assign green_out = buf_data.pix.green;
  assign blue_out  = buf_data.pix.blue;
  assign frame_end = buf_data.frame_end;

endmodule

`default_nettype wire

FILE: dv/rgb_median_filter_3x3_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register ports, predicts every result
// and compares it with what the filter sends out.
module rgb_median_filter_3x3_checker import rmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  input  logic                  padding,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            red_out,
  input  logic [7:0]            green_out,
  input  logic [7:0]            blue_out,
  input  logic                  frame_end,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pixels_pending,
  output int                    pixels_checked,
  output int                    pixels_filtered,
  output int                    frames_closed
);

  // Shadow copy of the frame geometry registers
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  // Shadow copy of the line buffers, window and raster position
  pixel_t      line_two_up [MAX_WIDTH];
  pixel_t      line_one_up [MAX_WIDTH];
  pixel_t      nbhd [TAPS][TAPS];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned out_pos;

  result_t     expected_pixels [$];
  int          errs;
  int          n_checked;
  int          n_filtered;
  int          n_frames;

  // Median of one color channel over the 3x3 neighborhood (ch: 0 red, 1 green, 2 blue)
  function automatic chan_t nbhd_median(input int ch);
    chan_t v [9];
    chan_t x;
    int    k;
    for (int i = 0; i < TAPS; i++)
      for (int j = 0; j < TAPS; j++)
        v[i*TAPS + j] = nbhd[i][j][8*(2-ch) +: 8];
    for (int i = 1; i < 9; i++) begin
      x = v[i];
      k = i;
      while (k > 0 && v[k-1] > x) begin
        v[k] = v[k-1];
        k--;
      end
      v[k] = x;
    end
    return v[4];
  endfunction

  // One accepted input transfer: advance the raster and queue any result it releases
  task automatic take_pixel(input pixel_t px, input logic pad);
    int unsigned w, h, c, r, orow, ocol;
    pixel_t      p, up, lo, val;
    logic        emit;
    result_t     res;
    w = width_reg;
    h = height_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    c = col_pos;
    r = row_pos;
    if (c >= MAX_WIDTH) c = 0;
    p = pad ? '0 : px;
    emit = 1'b0;
    val = '0;

    // start of a line releases the right-border pixel two lines up
    if (c == 0 && r >= 2) begin
      val = nbhd[1][TAPS-1];
      emit = 1'b1;
    end

    up = line_two_up[c];
    lo = line_one_up[c];
    line_two_up[c] = lo;
    line_one_up[c] = p;
    for (int i = 0; i < TAPS; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = lo;
    nbhd[2][2] = p;

    // center of the window: median inside the frame, pass-through on the border
    if (c >= 1 && r >= 1) begin
      orow = r - 1;
      ocol = c - 1;
      if (orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w) begin
        val.red   = nbhd_median(0);
        val.green = nbhd_median(1);
        val.blue  = nbhd_median(2);
        n_filtered++;
      end else begin
        val = nbhd[1][1];
      end
      emit = 1'b1;
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r < ROW_LIMIT) ? r + 1 : r;
    end else begin
      col_pos = c + 1;
    end

    if (emit) begin
      res.pix = val;
      if (out_pos + 1 >= w * h) begin
        res.frame_end = 1'b1;
        out_pos = 0;
        col_pos = 0;
        row_pos = 0;
      end else begin
        res.frame_end = 1'b0;
        out_pos++;
      end
      expected_pixels.push_back(res);
    end
  endtask

  // One result transfer against the oldest expectation
  task automatic check_pixel();
    result_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: red %0d green %0d blue %0d frame_end %0b",
             red_out, green_out, blue_out, frame_end);
      errs++;
    end else begin
      want = expected_pixels.pop_front();
      n_checked++;
      if (want.frame_end) n_frames++;
      if (red_out !== want.pix.red) begin
        $error("red_out: expected %0d, actual %0d", want.pix.red, red_out);
        errs++;
      end
      if (green_out !== want.pix.green) begin
        $error("green_out: expected %0d, actual %0d", want.pix.green, green_out);
        errs++;
      end
      if (blue_out !== want.pix.blue) begin
        $error("blue_out: expected %0d, actual %0d", want.pix.blue, blue_out);
        errs++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
        errs++;
      end
    end
  endtask

  // Results are compared before the same edge's input is predicted
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = CFG_DATA_W'(WIDTH_RESET);
      height_reg = CFG_DATA_W'(HEIGHT_RESET);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_two_up[i] = '0;
        line_one_up[i] = '0;
      end
      for (int i = 0; i < TAPS; i++)
        for (int j = 0; j < TAPS; j++)
          nbhd[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_IMAGE_WIDTH)
          width_reg = cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT)
          height_reg = cfg_data;
      end
      if (out_valid && out_ready)
        check_pixel();
      if (in_valid && in_ready)
        take_pixel({red_in, green_in, blue_in}, padding);
    end
    fail_count      <= errs;
    pixels_pending  <= expected_pixels.size();
    pixels_checked  <= n_checked;
    pixels_filtered <= n_filtered;
    frames_closed   <= n_frames;
  end

endmodule

FILE: dv/rgb_median_filter_3x3_tb.sv
`timescale 1ns / 1ps

module rgb_median_filter_3x3_tb;
  import rmf_pkg::*;

  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            red_in = '0;
  logic [7:0]            green_in = '0;
  logic [7:0]            blue_in = '0;
  logic                  padding = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            red_out;
  logic [7:0]            green_out;
  logic [7:0]            blue_out;
  logic                  frame_end;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pixels_pending;
  int pixels_checked;
  int pixels_filtered;
  int frames_closed;

  int tx_idle = 0;
  int rx_idle = 0;
  int items_sent = 0;
  int settings_used = 0;
  int quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rgb_median_filter_3x3 dut (
    .clk, .rst,
    .in_valid, .in_ready, .red_in, .green_in, .blue_in, .padding,
    .out_valid, .out_ready, .red_out, .green_out, .blue_out, .frame_end,
    .cfg_write, .cfg_index, .cfg_data
  );

  rgb_median_filter_3x3_checker u_check (
    .clk, .rst,
    .in_valid, .in_ready, .red_in, .green_in, .blue_in, .padding,
    .out_valid, .out_ready, .red_out, .green_out, .blue_out, .frame_end,
    .cfg_write, .cfg_index, .cfg_data,
    .fail_count, .pixels_pending, .pixels_checked, .pixels_filtered, .frames_closed
  );

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= rx_idle);
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Channel values biased toward the extremes and toward near-ties
  function automatic chan_t rand_chan();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      1:       return chan_t'(126 + $urandom_range(4));
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red   = rand_chan();
    p.green = rand_chan();
    p.blue  = rand_chan();
    return p;
  endfunction

  function automatic chan_t corner_chan(input int k);
    case (k % 8)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h55;
      3: return 8'hAA;
      4: return 8'h01;
      5: return 8'hFE;
      6: return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  // One input transfer, with an optional gap ahead of it
  task automatic put_item(input pixel_t px, input logic pad);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    red_in   <= px.red;
    green_in <= px.green;
    blue_in  <= px.blue;
    padding  <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Let the pipeline drain, then write both geometry registers
  task automatic configure(input int reg_w, input int reg_h);
    in_valid <= 1'b0;
    // pending count of the last transfer is registered in the checker
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(reg_w);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(reg_h);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Random frames at one geometry; flushes may be dropped and holes punched.
  // The tail is padded so the raster ends aligned to a frame boundary.
  task automatic stream_frames(input int reg_w, input int reg_h, input int frames,
                               input int skip_pct, input int hole_pct);
    int weff, heff, period, sent;
    weff = (reg_w == 0) ? 1 : (reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w;
    heff = (reg_h == 0) ? 1 : reg_h;
    period = weff * heff + weff + 1;
    sent = 0;
    configure(reg_w, reg_h);
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < weff * heff; i++) begin
        put_item(rand_pixel(), $urandom_range(99) < hole_pct);
        sent++;
      end
      if ($urandom_range(99) >= skip_pct) begin
        repeat (weff + 1) put_item(rand_pixel(), 1'b1);
        sent += weff + 1;
      end
    end
    while (sent % period != 0) begin
      put_item(rand_pixel(), 1'b1);
      sent++;
    end
  endtask

  initial begin
    pixel_t px;
    tx_idle = 15;
    rx_idle <= 64;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed 5x4 frame: corner values, a hole at an interior position, flush
    configure(5, 4);
    for (int i = 0; i < 20; i++) begin
      px.red   = corner_chan(i);
      px.green = corner_chan(3*i + 2);
      px.blue  = corner_chan(5*i + 5);
      put_item(px, i == 12);
    end
    repeat (6) put_item(rand_pixel(), 1'b1);

    // Sender idles lightly, receiver stalls often
    stream_frames(7, 6, 6, 0, 0);
    stream_frames(1, 1, 20, 0, 0);
    stream_frames(0, 0, 10, 30, 0);
    stream_frames(3, 3, 10, 30, 5);
    stream_frames(2, 5, 8, 0, 10);

    // Swapped: sender gaps often, receiver mostly ready
    tx_idle = 64;
    rx_idle <= 15;
    stream_frames(16, 9, 4, 25, 5);
    stream_frames(24, 1, 2, 0, 0);
    stream_frames(9, 2, 8, 0, 0);

    // Full rate on both sides
    tx_idle = 0;
    rx_idle <= 0;
    stream_frames(1, 60, 2, 0, 0);
    stream_frames(11, 7, 5, 20, 3);

    // Geometry shrinks part way through a frame
    configure(12, 8);
    repeat (12*3 + 5) put_item(rand_pixel(), 1'b0);
    configure(5, 4);
    repeat (40) put_item(rand_pixel(), $urandom_range(9) == 0);
    repeat (12) put_item(rand_pixel(), 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input transfers across %0d geometry settings and three idle mixes",
             items_sent, settings_used);
    $display("Checked %0d output pixels: %0d median-filtered, %0d frame ends",
             pixels_checked, pixels_filtered, frames_closed);
    if (fail_count == 0 && pixels_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
hdl/rmf_pkg.sv
hdl/rmf_ram.sv
hdl/rmf_median.sv
hdl/rmf_out_buf.sv
hdl/rgb_median_filter_3x3.sv
dv/rgb_median_filter_3x3_checker.sv
dv/rgb_median_filter_3x3_tb.sv
